>>> rtl/apc_pkg.sv
// types and constants shared by the argb pixel compositor
// no dependencies

package apc_pkg;

   // pixel format codes for both the source and the target register
   typedef enum logic [1:0] {
      FMT_XRGB  = 2'd0,
      FMT_ZRGB  = 2'd1,
      FMT_ARGB  = 2'd2,
      FMT_BARGB = 2'd3
   } fmt_type;

   // configuration register indexes
   localparam logic CSR_SOURCE_FORMAT = 1'b0;
   localparam logic CSR_TARGET_FORMAT = 1'b1;

   localparam logic [31:0] RGB_MASK  = 32'h00FF_FFFF;
   localparam logic [31:0] ALPHA_SET = 32'hFF00_0000;
   localparam logic [7:0]  FULL      = 8'd255;

   typedef struct packed {
      logic [31:0] source_pixel;
      logic [31:0] target_pixel;
   } req_type;

   typedef struct packed {
      logic [31:0] result_pixel;
      logic        write_enable;
   } rsp_type;

   typedef struct packed {
      fmt_type source_format;
      fmt_type target_format;
   } cfg_type;

   // truncated x / 255 for any 16-bit product of two bytes
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return sum[15:8];
   endfunction

endpackage

>>> rtl/apc_mix.sv
// one channel of the over blend: s*a/255 + t*(255-a)/255, each term truncated
// depends on apc_pkg

module apc_mix (
   input  logic [7:0] src_chan,
   input  logic [7:0] tgt_chan,
   input  logic [7:0] alpha,
   output logic [7:0] mix_chan
);

   logic [15:0] src_prod;
   logic [15:0] tgt_prod;
   logic [7:0]  inv_alpha;
   logic [8:0]  mix_sum;

   assign inv_alpha = apc_pkg::FULL - alpha;
   assign src_prod  = 16'(src_chan) * 16'(alpha);
   assign tgt_prod  = 16'(tgt_chan) * 16'(inv_alpha);
   assign mix_sum   = {1'b0, apc_pkg::div255(src_prod)} + {1'b0, apc_pkg::div255(tgt_prod)};
   // the two terms never sum past 255
   assign mix_chan  = mix_sum[7:0];

endmodule

>>> rtl/apc_datapath.sv
// mode selection and blend for one pixel pair, purely combinational
// depends on apc_pkg and apc_mix

module apc_datapath (
   input  apc_pkg::cfg_type cfg,
   input  apc_pkg::req_type req,
   output apc_pkg::rsp_type rsp
);

   logic [31:0] src;
   logic [31:0] tgt;
   logic [7:0]  alpha;
   logic        clear_alpha;
   logic [31:0] src_fixed;
   logic [7:0]  mix_r;
   logic [7:0]  mix_g;
   logic [7:0]  mix_b;
   logic [7:0]  mix_a;
   logic [7:0]  out_alpha;

   assign src         = req.source_pixel;
   assign tgt         = req.target_pixel;
   assign alpha       = src[31:24];
   assign clear_alpha = (cfg.target_format == apc_pkg::FMT_ZRGB);
   assign src_fixed   = clear_alpha ? (src & apc_pkg::RGB_MASK) : src;

   apc_mix u_mix_r (.src_chan(src[7:0]),   .tgt_chan(tgt[7:0]),   .alpha(alpha), .mix_chan(mix_r));
   apc_mix u_mix_g (.src_chan(src[15:8]),  .tgt_chan(tgt[15:8]),  .alpha(alpha), .mix_chan(mix_g));
   apc_mix u_mix_b (.src_chan(src[23:16]), .tgt_chan(tgt[23:16]), .alpha(alpha), .mix_chan(mix_b));
   // 255*a/255 is exactly a, so the same unit gives the over alpha
   apc_mix u_mix_a (.src_chan(apc_pkg::FULL), .tgt_chan(tgt[31:24]), .alpha(alpha),
                    .mix_chan(mix_a));

   assign out_alpha = clear_alpha ? 8'd0 : mix_a;

   always_comb begin
      rsp.result_pixel = tgt;
      rsp.write_enable = 1'b0;
      unique case (cfg.source_format)
         apc_pkg::FMT_BARGB: begin
            if (src[31]) begin
               rsp.result_pixel = src_fixed;
               rsp.write_enable = 1'b1;
            end
         end
         apc_pkg::FMT_ARGB: begin
            if (alpha == apc_pkg::FULL) begin
               rsp.result_pixel = src_fixed;
               rsp.write_enable = 1'b1;
            end else if (alpha != 8'd0) begin
               rsp.result_pixel = {out_alpha, mix_b, mix_g, mix_r};
               rsp.write_enable = 1'b1;
            end
         end
         apc_pkg::FMT_XRGB,
         apc_pkg::FMT_ZRGB: begin
            rsp.write_enable = 1'b1;
            priority if (cfg.target_format == apc_pkg::FMT_ARGB ||
                         cfg.target_format == apc_pkg::FMT_BARGB) begin
               rsp.result_pixel = (src & apc_pkg::RGB_MASK) | apc_pkg::ALPHA_SET;
            end else if (clear_alpha && cfg.source_format == apc_pkg::FMT_XRGB) begin
               rsp.result_pixel = src & apc_pkg::RGB_MASK;
            end else begin
               rsp.result_pixel = src;
            end
         end
         default: begin
            rsp.result_pixel = tgt;
            rsp.write_enable = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/argb_pixel_compositor.sv
// top level of the argb pixel compositor: input, config and result registers
// depends on apc_pkg and apc_datapath

// usage
// - req channel: a pixel pair beat is taken at each rising edge with start high
//   and busy low; busy is high only while reset is held, so one beat per cycle
// - rsp channel: rsp_valid strobes for exactly one cycle with the new target
//   pixel and its write flag; the receiver has no way to stall the block
// - csr channel: csr_index 0 selects source_format, 1 selects target_format;
//   csr_ready is always high, writes take effect in the following cycle and should only be made
//   while no pixel beat is in flight
// data path: one input register, then the blend logic, then one result register
// throughput: one pixel pair per clock, set by the single blend stage
// reset: synchronous, clears both formats to xrgb and empties the pipeline;
//   beats in flight at reset are dropped

module argb_pixel_compositor (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  apc_pkg::req_type req_data,
   output logic             rsp_valid,
   output apc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [1:0]       csr_wdata
);

   apc_pkg::cfg_type cfg_ff;
   apc_pkg::cfg_type cfg_in;
   logic             in_valid_ff;
   apc_pkg::req_type in_ff;
   logic             out_valid_ff;
   apc_pkg::rsp_type out_ff;
   apc_pkg::rsp_type out_in;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // config register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            apc_pkg::CSR_SOURCE_FORMAT: cfg_in.source_format = apc_pkg::fmt_type'(csr_wdata);
            apc_pkg::CSR_TARGET_FORMAT: cfg_in.target_format = apc_pkg::fmt_type'(csr_wdata);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format <= apc_pkg::FMT_XRGB;
         cfg_ff.target_format <= apc_pkg::FMT_XRGB;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_ff <= req_data;
      end
   end

   // mode select and per channel blend
   apc_datapath u_datapath (
      .cfg (cfg_ff),
      .req (in_ff),
      .rsp (out_in)
   );

   // result register, strobe lasts one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // every accepted beat gives exactly one result after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted beat produced no result");

   // no result without a beat in the input register the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid_ff))
      else $error("result strobe without a beat");

   // a result without a write carries the old target pixel
   a_keep_target: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |=> (!rsp_valid || rsp_data.write_enable ||
                       rsp_data.result_pixel == $past(in_ff.target_pixel)))
      else $error("unwritten pixel differs from target");

endmodule
